// ===== design/wbrp_pkg.sv =====
`timescale 1ns / 1ps

package wbrp_pkg;

  localparam int LENGTH_BITS   = 32;
  localparam int POSITION_BITS = 32;
  localparam int HEADER_BYTES  = 12;
  localparam int SEQ_BYTES     = 8;
  localparam int PADDR_BITS    = 6;
  localparam int PDATA_BITS    = 64;
  localparam int LOC_BITS      = 33;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  // event kinds
  localparam logic [2:0] EV_KEY     = 3'd0;
  localparam logic [2:0] EV_VALUE   = 3'd1;
  localparam logic [2:0] EV_PUT_END = 3'd2;
  localparam logic [2:0] EV_DEL_END = 3'd3;
  localparam logic [2:0] EV_SEP_END = 3'd4;
  localparam logic [2:0] EV_STATUS  = 3'd5;

  // batch status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
  localparam logic [2:0] ST_BAD_PUT     = 3'd2;
  localparam logic [2:0] ST_BAD_DELETE  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_TAG = 3'd4;
  localparam logic [2:0] ST_WRONG_COUNT = 3'd5;

  // register indexes
  localparam logic [2:0] REG_FILE_NUMBER  = 3'd0;
  localparam logic [2:0] REG_LOG_OFFSET   = 3'd1;
  localparam logic [2:0] REG_VALUE_TAG    = 3'd2;
  localparam logic [2:0] REG_DELETION_TAG = 3'd3;
  localparam logic [2:0] REG_SEPARATE_TAG = 3'd4;

  typedef struct packed {
    logic [31:0] log_offset;
    logic [7:0]  value_tag;
    logic [7:0]  deletion_tag;
    logic [7:0]  separate_tag;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          event_kind;
    logic [7:0]          data_byte;
    logic [63:0]         sequence_number;
    logic [LOC_BITS-1:0] value_location;
    logic [31:0]         value_length;
    logic [2:0]          status;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== design/wbrp_ifs.sv =====
`timescale 1ns / 1ps

interface wbrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] batch_byte;
  logic       final_byte;

  modport source (output valid, output batch_byte, output final_byte, input ready);
  modport sink (input valid, input batch_byte, input final_byte, output ready);
endinterface

interface wbrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  data_byte;
  logic [63:0] sequence_number;
  logic [32:0] value_location;
  logic [31:0] value_length;
  logic [2:0]  status;

  modport source (output valid, output event_kind, output data_byte,
                  output sequence_number, output value_location,
                  output value_length, output status, input ready);
  modport sink (input valid, input event_kind, input data_byte,
                input sequence_number, input value_location,
                input value_length, input status, output ready);
endinterface

// ===== design/wbrp_cfg.sv =====
`timescale 1ns / 1ps

module wbrp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wbrp_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [wbrp_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [wbrp_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                pready,
  output wbrp_pkg::cfg_t                      cfg
);

  logic [63:0] file_number;
  logic [31:0] log_offset;
  logic [7:0]  value_tag;
  logic [7:0]  deletion_tag;
  logic [7:0]  separate_tag;
  logic [2:0]  reg_index;
  logic        wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[5:3];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_number  <= 64'd0;
      log_offset   <= 32'd0;
      value_tag    <= 8'd1;
      deletion_tag <= 8'd0;
      separate_tag <= 8'd2;
    end else if (wr_en) begin
      case (reg_index)
        wbrp_pkg::REG_FILE_NUMBER:  file_number  <= pwdata;
        wbrp_pkg::REG_LOG_OFFSET:   log_offset   <= pwdata[31:0];
        wbrp_pkg::REG_VALUE_TAG:    value_tag    <= pwdata[7:0];
        wbrp_pkg::REG_DELETION_TAG: deletion_tag <= pwdata[7:0];
        wbrp_pkg::REG_SEPARATE_TAG: separate_tag <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      wbrp_pkg::REG_FILE_NUMBER:  prdata = file_number;
      wbrp_pkg::REG_LOG_OFFSET:   prdata = {32'd0, log_offset};
      wbrp_pkg::REG_VALUE_TAG:    prdata = {56'd0, value_tag};
      wbrp_pkg::REG_DELETION_TAG: prdata = {56'd0, deletion_tag};
      wbrp_pkg::REG_SEPARATE_TAG: prdata = {56'd0, separate_tag};
      default:                    prdata = 64'd0;
    endcase
  end

  assign cfg.log_offset   = log_offset;
  assign cfg.value_tag    = value_tag;
  assign cfg.deletion_tag = deletion_tag;
  assign cfg.separate_tag = separate_tag;

endmodule

// ===== design/wbrp_core.sv =====
`timescale 1ns / 1ps

module wbrp_core (
  input  logic             clk,
  input  logic             rst,
  input  wbrp_pkg::cfg_t   cfg,
  input  logic             room,
  wbrp_in_if.sink          batch,
  output wbrp_pkg::push_t  push
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_KEYLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_VALLEN = 3'd4,
    PH_VAL    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    RK_PUT = 2'd0,
    RK_DEL = 2'd1,
    RK_SEP = 2'd2
  } rkind_t;

  localparam int PB = wbrp_pkg::POSITION_BITS;

  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_final;
  logic       go;

  phase_t       phase, phase_next;
  logic [3:0]   header_index, header_index_next;
  logic [63:0]  next_sequence, next_sequence_next;
  logic [31:0]  expected_count, expected_count_next;
  logic [31:0]  records_seen, records_seen_next;
  logic [31:0]  length_accumulator, length_accumulator_next;
  logic [2:0]   varint_shift, varint_shift_next;
  logic [31:0]  remaining_bytes, remaining_bytes_next;
  rkind_t       record_kind, record_kind_next;
  logic [PB-1:0] byte_position, byte_position_next;
  logic [PB-1:0] record_start, record_start_next;
  logic         error_latched, error_latched_next;

  wbrp_pkg::result_t res [2];
  logic [1:0]  n;
  logic [2:0]  err;
  logic        ended;
  logic [31:0] chunk;
  logic [31:0] acc_upd;
  logic [2:0]  shift_upd;
  logic        vint_more;
  logic        vint_done;
  logic        vint_bad;
  logic [2:0]  st;

  function automatic wbrp_pkg::result_t end_event(rkind_t rk, logic [63:0] seq,
                                                  logic [31:0] offs, logic [PB-1:0] start,
                                                  logic [31:0] len);
    wbrp_pkg::result_t r;
    r = '0;
    r.sequence_number = seq;
    unique case (rk)
      RK_PUT: r.event_kind = wbrp_pkg::EV_PUT_END;
      RK_DEL: r.event_kind = wbrp_pkg::EV_DEL_END;
      default: begin
        r.event_kind     = wbrp_pkg::EV_SEP_END;
        r.value_location = wbrp_pkg::LOC_BITS'(offs) + wbrp_pkg::LOC_BITS'(start);
        r.value_length   = len;
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] bad_status(rkind_t rk);
    return (rk == RK_DEL) ? wbrp_pkg::ST_BAD_DELETE : wbrp_pkg::ST_BAD_PUT;
  endfunction

  assign go          = inq_valid && room;
  assign batch.ready = !inq_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (batch.ready) begin
      inq_valid <= batch.valid;
    end
    if (batch.valid && batch.ready) begin
      inq_byte  <= batch.batch_byte;
      inq_final <= batch.final_byte;
    end
  end

  always_comb begin
    unique case (varint_shift)
      3'd0:    chunk = {25'd0, inq_byte[6:0]};
      3'd1:    chunk = {18'd0, inq_byte[6:0], 7'd0};
      3'd2:    chunk = {11'd0, inq_byte[6:0], 14'd0};
      3'd3:    chunk = {4'd0, inq_byte[6:0], 21'd0};
      3'd4:    chunk = {inq_byte[3:0], 28'd0};
      default: chunk = 32'd0;
    endcase
    acc_upd   = length_accumulator | chunk;
    shift_upd = varint_shift + 3'd1;
    vint_more = inq_byte[7] && (shift_upd < 3'd5);
    vint_bad  = inq_byte[7] ? (shift_upd >= 3'd5) : (acc_upd > wbrp_pkg::LEN_MASK);
    vint_done = !inq_byte[7] && !vint_bad;
  end

  always_comb begin
    phase_next              = phase;
    header_index_next       = header_index;
    next_sequence_next      = next_sequence;
    expected_count_next     = expected_count;
    records_seen_next       = records_seen;
    length_accumulator_next = length_accumulator;
    varint_shift_next       = varint_shift;
    remaining_bytes_next    = remaining_bytes;
    record_kind_next        = record_kind;
    byte_position_next      = byte_position;
    record_start_next       = record_start;
    error_latched_next      = error_latched;
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    err    = wbrp_pkg::ST_OK;
    ended  = 1'b0;
    st     = wbrp_pkg::ST_OK;

    if (!error_latched) begin
      byte_position_next = byte_position + PB'(1);
      unique case (phase)
        PH_HEADER: begin
          for (int i = 0; i < wbrp_pkg::SEQ_BYTES; i++) begin
            if (header_index == 4'(i)) next_sequence_next[8*i +: 8] = inq_byte;
          end
          for (int i = 0; i < wbrp_pkg::HEADER_BYTES - wbrp_pkg::SEQ_BYTES; i++) begin
            if (header_index == 4'(i + wbrp_pkg::SEQ_BYTES)) begin
              expected_count_next[8*i +: 8] = inq_byte;
            end
          end
          header_index_next = header_index + 4'd1;
          if (header_index_next >= 4'(wbrp_pkg::HEADER_BYTES)) phase_next = PH_TAG;
        end
        PH_TAG: begin
          record_start_next = byte_position;
          records_seen_next = records_seen + 32'd1;
          priority if (inq_byte == cfg.value_tag) begin
            record_kind_next = RK_PUT;
          end else if (inq_byte == cfg.deletion_tag) begin
            record_kind_next = RK_DEL;
          end else if (inq_byte == cfg.separate_tag) begin
            record_kind_next = RK_SEP;
          end else begin
            err = wbrp_pkg::ST_UNKNOWN_TAG;
          end
          if (err == wbrp_pkg::ST_OK) begin
            length_accumulator_next = 32'd0;
            varint_shift_next       = 3'd0;
            phase_next              = PH_KEYLEN;
          end
        end
        PH_KEYLEN, PH_VALLEN: begin
          length_accumulator_next = acc_upd;
          varint_shift_next       = shift_upd;
          if (vint_bad) begin
            err = bad_status(record_kind);
          end else if (vint_done) begin
            remaining_bytes_next = acc_upd;
            if (acc_upd != 32'd0) begin
              phase_next = (phase == PH_KEYLEN) ? PH_KEY : PH_VAL;
            end else if (phase == PH_KEYLEN && record_kind != RK_DEL) begin
              length_accumulator_next = 32'd0;
              varint_shift_next       = 3'd0;
              phase_next              = PH_VALLEN;
            end else begin
              res[0] = end_event(record_kind, next_sequence, cfg.log_offset,
                                 record_start, acc_upd);
              n = 2'd1;
              next_sequence_next = next_sequence + 64'd1;
              phase_next = PH_TAG;
              ended = 1'b1;
            end
          end else if (!vint_more) begin
            err = bad_status(record_kind);
          end
        end
        PH_KEY, PH_VAL: begin
          if (phase == PH_KEY || record_kind != RK_SEP) begin
            res[0].event_kind = (phase == PH_KEY) ? wbrp_pkg::EV_KEY : wbrp_pkg::EV_VALUE;
            res[0].data_byte  = inq_byte;
            n = 2'd1;
          end
          remaining_bytes_next = remaining_bytes - 32'd1;
          if (remaining_bytes_next == 32'd0) begin
            if (phase == PH_KEY && record_kind != RK_DEL) begin
              length_accumulator_next = 32'd0;
              varint_shift_next       = 3'd0;
              phase_next              = PH_VALLEN;
            end else begin
              res[n[0]] = end_event(record_kind, next_sequence, cfg.log_offset,
                                    record_start, length_accumulator);
              n = n + 2'd1;
              next_sequence_next = next_sequence + 64'd1;
              phase_next = PH_TAG;
              ended = 1'b1;
            end
          end
        end
        default: phase_next = PH_HEADER;
      endcase

      if (err != wbrp_pkg::ST_OK) begin
        res[0] = '0;
        res[0].event_kind = wbrp_pkg::EV_STATUS;
        res[0].status     = err;
        n = 2'd1;
        error_latched_next = 1'b1;
      end else if (inq_final) begin
        priority if (phase_next == PH_HEADER) begin
          st = wbrp_pkg::ST_TOO_SMALL;
        end else if (phase_next == PH_TAG) begin
          st = (records_seen_next == expected_count_next) ? wbrp_pkg::ST_OK
                                                          : wbrp_pkg::ST_WRONG_COUNT;
        end else begin
          st = bad_status(record_kind_next);
        end
        if (ended) begin
          res[n[1]].status = st;
        end else begin
          res[n[0]] = '0;
          res[n[0]].event_kind = wbrp_pkg::EV_STATUS;
          res[n[0]].status     = st;
          n = n + 2'd1;
        end
      end
    end

    // rearm for the next batch
    if (inq_final) begin
      phase_next              = PH_HEADER;
      header_index_next       = 4'd0;
      next_sequence_next      = 64'd0;
      expected_count_next     = 32'd0;
      records_seen_next       = 32'd0;
      length_accumulator_next = 32'd0;
      varint_shift_next       = 3'd0;
      remaining_bytes_next    = 32'd0;
      record_kind_next        = RK_PUT;
      byte_position_next      = '0;
      record_start_next       = '0;
      error_latched_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      header_index       <= 4'd0;
      next_sequence      <= 64'd0;
      expected_count     <= 32'd0;
      records_seen       <= 32'd0;
      length_accumulator <= 32'd0;
      varint_shift       <= 3'd0;
      remaining_bytes    <= 32'd0;
      record_kind        <= RK_PUT;
      byte_position      <= '0;
      record_start       <= '0;
      error_latched      <= 1'b0;
    end else if (go) begin
      phase              <= phase_next;
      header_index       <= header_index_next;
      next_sequence      <= next_sequence_next;
      expected_count     <= expected_count_next;
      records_seen       <= records_seen_next;
      length_accumulator <= length_accumulator_next;
      varint_shift       <= varint_shift_next;
      remaining_bytes    <= remaining_bytes_next;
      record_kind        <= record_kind_next;
      byte_position      <= byte_position_next;
      record_start       <= record_start_next;
      error_latched      <= error_latched_next;
    end
  end

  assign push.count  = go ? n : 2'd0;
  assign push.first  = res[0];
  assign push.second = res[1];

  a_latched_silent: assert property (@(posedge clk) disable iff (rst)
    (go && error_latched) |-> push.count == 2'd0)
    else $error("result pushed while error latched");

  a_final_rearms: assert property (@(posedge clk) disable iff (rst)
    (go && inq_final) |=> (phase == PH_HEADER && !error_latched && header_index == 4'd0))
    else $error("parser not rearmed after final byte");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |->
      (push.first.event_kind == wbrp_pkg::EV_KEY ||
       push.first.event_kind == wbrp_pkg::EV_VALUE))
    else $error("two results without a data byte first");

endmodule

// ===== design/wbrp_outq.sv =====
`timescale 1ns / 1ps

module wbrp_outq (
  input  logic             clk,
  input  logic             rst,
  input  wbrp_pkg::push_t  push,
  output logic             room,
  wbrp_out_if.source       events
);

  localparam int QD = wbrp_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(QD);

  wbrp_pkg::result_t entries [QD];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          pop;
  wbrp_pkg::result_t head;

  assign pop  = events.valid && events.ready;
  assign room = count <= (AW + 1)'(QD - 2);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + (AW + 1)'(push.count) - (AW + 1)'(pop);
    end
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + AW'(1)] <= push.second;
  end

  assign events.valid           = count != '0;
  assign events.event_kind      = head.event_kind;
  assign events.data_byte       = head.data_byte;
  assign events.sequence_number = head.sequence_number;
  assign events.value_location  = head.value_location;
  assign events.value_length    = head.value_length;
  assign events.status          = head.status;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(QD))
    else $error("result buffer overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("transaction pushed without buffer room");

endmodule

// ===== design/write_batch_record_parser.sv =====
`timescale 1ns / 1ps
// Pipeline: a byte accepted is held in the input register and parsed from there;
// its results are written into the result buffer and offered from its head.
// Throughput: one byte per cycle while the result buffer has room; a byte that
// yields two results (data byte plus record end or status) writes both into the
// four-entry result buffer. Synchronous reset clears parser state, the buffer
// and restores configuration registers to their defaults.

module write_batch_record_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wbrp_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [wbrp_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [wbrp_pkg::PDATA_BITS-1:0]  prdata,
  output logic                             pready,
  wbrp_in_if.sink                          batch,
  wbrp_out_if.source                       events
);

  wbrp_pkg::cfg_t  cfg;
  wbrp_pkg::push_t push;
  logic            room;

  wbrp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wbrp_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .room  (room),
    .batch (batch),
    .push  (push)
  );

  wbrp_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .events (events)
  );

endmodule
